### src/nash_cascade_router_assert.svh
// Assertion macros used by the checker of the routing block.
`ifndef NASH_CASCADE_ROUTER_ASSERT_SVH
`define NASH_CASCADE_ROUTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define NCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define NCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/ncr_pkg.sv
`default_nettype none
package ncr_pkg;

    localparam int MAX_RESERVOIRS = 8;
    localparam int MAX_SUBSTEPS   = 64;
    localparam int RES_IW         = (MAX_RESERVOIRS > 1) ? $clog2(MAX_RESERVOIRS) : 1;
    localparam int SUB_IW         = $clog2(MAX_SUBSTEPS);

    localparam int Q_W    = 32;
    localparam int GAIN_W = 20;
    localparam int NSUB_W = 7;
    localparam int NRES_W = 4;
    localparam int REL_W  = 36;
    localparam int CFG_IW = 2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_SUBSTEP_GAIN    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SUBSTEP_COUNT   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RESERVOIR_COUNT = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd65536;
    localparam logic [NSUB_W-1:0] NSUB_RESET = 7'd1;
    localparam logic [NRES_W-1:0] NRES_RESET = 4'd2;

    typedef logic [RES_IW-1:0] t_idx;
    typedef logic [SUB_IW-1:0] t_sub;
    typedef logic [3:0]        t_pc;

    // Program addresses.
    localparam t_pc PC_WAIT    = 4'd0;
    localparam t_pc PC_LOAD    = 4'd1;
    localparam t_pc PC_READ    = 4'd2;
    localparam t_pc PC_MUL     = 4'd3;
    localparam t_pc PC_SUB     = 4'd4;
    localparam t_pc PC_ADDNEXT = 4'd5;
    localparam t_pc PC_ADV     = 4'd6;
    localparam t_pc PC_ADDOUT  = 4'd7;
    localparam t_pc PC_EMIT    = 4'd8;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_LOAD,
        DP_READ,
        DP_MUL,
        DP_SUB,
        DP_ADD_NEXT,
        DP_ADD_OUT,
        DP_EMIT
    } t_dp_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_NO_IN,
        C_ZERO,
        C_LAST,
        C_BUSY,
        C_LOOP
    } t_cond;

    typedef struct packed {
        t_dp_op dp;
        t_cond  cond;
        t_pc    target;
    } t_uword;

    typedef struct packed {
        t_dp_op dp;
        t_idx   idx;
        logic   in_acc;
    } t_ctrl;

    typedef struct packed {
        logic zero;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        t_idx nres_last;
        t_sub nsub_last;
    } t_limits;

endpackage
`default_nettype wire

### src/nash_cascade_router.sv
// Channel  Handshake                 Payload
// in       i_in_valid / o_in_stall   i_runoff_depth[31:0]
// out      o_out_valid / i_out_stall o_channel_outflow[31:0], o_saturated
// cfg      i_cfg_we                  i_cfg_index[1:0], i_cfg_data[19:0]
//
// One beat is processed by a microprogram loop over substeps and reservoirs,
// up to 64 x 8, sharing one multiplier and one read port; an empty reservoir
// skips the multiply, subtract and add steps.
// Synchronous active-low reset clears storage, counters and output valid flag.
// The output register holds a result under stall; the next beat is accepted
// meanwhile and its result waits in the emit step until that clears.
`default_nettype none
module nash_cascade_router (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [ncr_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire  [ncr_pkg::GAIN_W-1:0]  i_cfg_data,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  [ncr_pkg::Q_W-1:0]     i_runoff_depth,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [ncr_pkg::Q_W-1:0]     o_channel_outflow,
    output logic                        o_saturated
);
    import ncr_pkg::*;

    t_ctrl   ctrl;
    t_stat   stat;
    t_limits lim;

    ncr_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .i_lim      (lim),
        .o_ctrl     (ctrl),
        .o_in_stall (o_in_stall)
    );

    ncr_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_ctrl            (ctrl),
        .i_runoff_depth    (i_runoff_depth),
        .i_out_stall       (i_out_stall),
        .o_stat            (stat),
        .o_lim             (lim),
        .o_out_valid       (o_out_valid),
        .o_channel_outflow (o_channel_outflow),
        .o_saturated       (o_saturated)
    );

endmodule
`default_nettype wire

### src/ncr_sequencer.sv
`default_nettype none
module ncr_sequencer (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  ncr_pkg::t_stat   i_stat,
    input  ncr_pkg::t_limits i_lim,
    output ncr_pkg::t_ctrl   o_ctrl,
    output logic             o_in_stall
);
    import ncr_pkg::*;

    t_pc    r_pc, n_pc;
    t_idx   r_idx, n_idx;
    t_sub   r_ts, n_ts;
    t_uword uw;

    // Microprogram: one control word per step.
    function automatic t_uword rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_WAIT:    w = '{DP_ACCEPT,   C_NO_IN, PC_WAIT};
            PC_LOAD:    w = '{DP_LOAD,     C_NEXT,  PC_WAIT};
            PC_READ:    w = '{DP_READ,     C_ZERO,  PC_ADV};
            PC_MUL:     w = '{DP_MUL,      C_NEXT,  PC_WAIT};
            PC_SUB:     w = '{DP_SUB,      C_LAST,  PC_ADDOUT};
            PC_ADDNEXT: w = '{DP_ADD_NEXT, C_LOOP,  PC_WAIT};
            PC_ADV:     w = '{DP_NONE,     C_LOOP,  PC_WAIT};
            PC_ADDOUT:  w = '{DP_ADD_OUT,  C_LOOP,  PC_WAIT};
            PC_EMIT:    w = '{DP_EMIT,     C_BUSY,  PC_WAIT};
            default:    w = '{DP_NONE,     C_JUMP,  PC_WAIT};
        endcase
        return w;
    endfunction

    assign uw         = rom(r_pc);
    assign o_in_stall = !i_rst_n || (r_pc != PC_WAIT);
    assign o_ctrl     = '{uw.dp, r_idx, i_in_valid && (r_pc == PC_WAIT)};

    always_comb begin
        n_pc  = r_pc + 4'd1;
        n_idx = r_idx;
        n_ts  = r_ts;
        unique case (uw.cond)
            C_NEXT: n_pc = r_pc + 4'd1;
            C_JUMP: n_pc = uw.target;
            C_NO_IN: begin
                if (!i_in_valid) n_pc = uw.target;
            end
            C_ZERO: begin
                if (i_stat.zero) n_pc = uw.target;
            end
            C_LAST: begin
                if (r_idx == i_lim.nres_last) n_pc = uw.target;
            end
            C_BUSY: begin
                n_pc = i_stat.out_busy ? r_pc : uw.target;
            end
            C_LOOP: begin
                // Next reservoir, then next substep, then hand the result over.
                if (r_idx != i_lim.nres_last) begin
                    n_idx = r_idx + 1'b1;
                    n_pc  = PC_READ;
                end else begin
                    n_idx = '0;
                    if (r_ts != i_lim.nsub_last) begin
                        n_ts = r_ts + 1'b1;
                        n_pc = PC_READ;
                    end else begin
                        n_ts = '0;
                        n_pc = PC_EMIT;
                    end
                end
            end
            default: n_pc = PC_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_WAIT;
            r_idx <= '0;
            r_ts  <= '0;
        end else begin
            r_pc  <= n_pc;
            r_idx <= n_idx;
            r_ts  <= n_ts;
        end
    end

endmodule
`default_nettype wire

### src/ncr_datapath.sv
`default_nettype none
module ncr_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [ncr_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire  [ncr_pkg::GAIN_W-1:0]   i_cfg_data,
    input  ncr_pkg::t_ctrl               i_ctrl,
    input  wire  [ncr_pkg::Q_W-1:0]      i_runoff_depth,
    input  wire                          i_out_stall,
    output ncr_pkg::t_stat               o_stat,
    output ncr_pkg::t_limits             o_lim,
    output logic                         o_out_valid,
    output logic [ncr_pkg::Q_W-1:0]      o_channel_outflow,
    output logic                         o_saturated
);
    import ncr_pkg::*;

    logic [GAIN_W-1:0] r_gain;
    logic [NSUB_W-1:0] r_nsub;
    logic [NRES_W-1:0] r_nres;

    logic [Q_W-1:0]   r_stor [MAX_RESERVOIRS];
    logic [Q_W-1:0]   r_run, r_s, r_a, r_ds, r_total;
    logic [REL_W-1:0] r_rel;
    logic             r_sat;
    logic             r_out_valid;
    logic [Q_W-1:0]   r_out_data;
    logic             r_out_sat;

    t_idx             rd_addr, idx_p1;
    logic [Q_W-1:0]   rd_data, ds, sub_res;
    logic [Q_W:0]     sum_in, sum_next;
    logic [REL_W:0]   sum_out;
    logic [51:0]      prod;
    logic             out_busy;
    int               nres_eff, nsub_eff;

    // Clamp the counts to their legal ranges.
    always_comb begin
        nres_eff = int'(r_nres);
        if (nres_eff == 0) nres_eff = 1;
        if (nres_eff > MAX_RESERVOIRS) nres_eff = MAX_RESERVOIRS;
        nsub_eff = int'(r_nsub);
        if (nsub_eff == 0) nsub_eff = 1;
        if (nsub_eff > MAX_SUBSTEPS) nsub_eff = MAX_SUBSTEPS;
    end

    assign o_lim.nres_last = RES_IW'(nres_eff - 1);
    assign o_lim.nsub_last = SUB_IW'(nsub_eff - 1);

    // One read port: the reservoir itself, its successor during the update, or reservoir 0 during the load.
    assign idx_p1 = i_ctrl.idx + 1'b1;
    always_comb begin
        unique case (i_ctrl.dp)
            DP_LOAD: rd_addr = '0;
            DP_SUB:  rd_addr = idx_p1;
            default: rd_addr = i_ctrl.idx;
        endcase
    end
    assign rd_data = r_stor[rd_addr];

    assign prod     = {20'd0, r_s} * {32'd0, r_gain};
    assign ds       = (r_rel < {4'd0, r_s}) ? r_rel[Q_W-1:0] : r_s;
    assign sub_res  = r_s - ds;
    assign sum_in   = {1'b0, rd_data} + {1'b0, r_run};
    assign sum_next = {1'b0, r_a} + {1'b0, r_ds};
    assign sum_out  = {5'd0, r_total} + {1'b0, r_rel};

    assign out_busy        = r_out_valid && i_out_stall;
    assign o_stat.zero     = (rd_data == '0);
    assign o_stat.out_busy = out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_nsub <= NSUB_RESET;
            r_nres <= NRES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SUBSTEP_GAIN:    r_gain <= i_cfg_data;
                CFG_SUBSTEP_COUNT:   r_nsub <= i_cfg_data[NSUB_W-1:0];
                CFG_RESERVOIR_COUNT: r_nres <= i_cfg_data[NRES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_RESERVOIRS; k++) r_stor[k] <= '0;
            r_sat       <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_ctrl.dp)
                DP_ACCEPT: begin
                    if (i_ctrl.in_acc) begin
                        r_run   <= i_runoff_depth;
                        r_total <= '0;
                        r_sat   <= 1'b0;
                    end
                end
                DP_LOAD: begin
                    if (sum_in[Q_W]) begin
                        r_stor[0] <= '1;
                        r_sat     <= 1'b1;
                    end else begin
                        r_stor[0] <= sum_in[Q_W-1:0];
                    end
                end
                DP_READ: r_s <= rd_data;
                DP_MUL:  r_rel <= prod[51:16];
                DP_SUB: begin
                    r_stor[i_ctrl.idx] <= sub_res;
                    r_ds               <= ds;
                    r_a                <= rd_data;
                end
                DP_ADD_NEXT: begin
                    if (sum_next[Q_W]) begin
                        r_stor[idx_p1] <= '1;
                        r_sat          <= 1'b1;
                    end else begin
                        r_stor[idx_p1] <= sum_next[Q_W-1:0];
                    end
                end
                DP_ADD_OUT: begin
                    if (sum_out[REL_W:Q_W] != '0) begin
                        r_total <= '1;
                        r_sat   <= 1'b1;
                    end else begin
                        r_total <= sum_out[Q_W-1:0];
                    end
                end
                DP_EMIT, DP_NONE: ;
                default: ;
            endcase

            if (i_ctrl.dp == DP_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_total;
                r_out_sat   <= r_sat;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_channel_outflow = r_out_data;
    assign o_saturated       = r_out_sat;

endmodule
`default_nettype wire

### src/ncr_checker.sv
`default_nettype none
`include "nash_cascade_router_assert.svh"
module ncr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_stall,
    input wire        i_out_valid,
    input wire        i_out_stall,
    input wire [31:0] i_channel_outflow
);
    logic in_acc;
    logic out_hold;
    assign in_acc   = i_in_valid && !i_in_stall;
    assign out_hold = i_out_valid && i_out_stall;

    // A result under stall stays put.
    `NCR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_hold, i_out_valid && $stable(i_channel_outflow))
    // Once a beat is taken the block is busy with it.
    `NCR_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, in_acc, i_in_stall)
    // No result can appear right after a beat is taken.
    `NCR_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, in_acc, !$rose(i_out_valid))
    // A new result appears just as the block returns to waiting for input.
    `NCR_ASSERT_NOW(a_result_frees_input, i_clk, i_rst_n, $rose(i_out_valid), !i_in_stall)

endmodule

bind nash_cascade_router ncr_checker u_ncr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .i_in_stall        (o_in_stall),
    .i_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .i_channel_outflow (o_channel_outflow)
);
`default_nettype wire
